// File: hdl/pfpm_pkg.sv
// Shared types, pattern tables and sizes for the packet fixed pattern matcher.
`default_nettype none

package pfpm_pkg;

   // Default scan window in bytes; matches must lie inside it.
   localparam int unsigned WINDOW_DEFAULT = 512;

   // A match must start more than this many bytes before the end of the window.
   localparam int unsigned START_MARGIN = 40;

   // Pattern lengths.
   localparam int unsigned URI_LEN       = 35;
   localparam int unsigned TAG_LONG_LEN  = 5;
   localparam int unsigned TAG_SHORT_LEN = 3;

   // Cells in the history chain: the longest pattern less the current byte.
   localparam int unsigned HIST_LEN = URI_LEN - 1;

   // Script path "phpunit/src/Util/PHP/eval-stdin.php", first byte first.
   localparam logic [7:0] URI_PAT [URI_LEN] = '{
      8'h70, 8'h68, 8'h70, 8'h75, 8'h6E, 8'h69, 8'h74, 8'h2F,
      8'h73, 8'h72, 8'h63, 8'h2F, 8'h55, 8'h74, 8'h69, 8'h6C,
      8'h2F, 8'h50, 8'h48, 8'h50, 8'h2F, 8'h65, 8'h76, 8'h61,
      8'h6C, 8'h2D, 8'h73, 8'h74, 8'h64, 8'h69, 8'h6E, 8'h2E,
      8'h70, 8'h68, 8'h70
   };

   // "<?php"
   localparam logic [7:0] TAG_LONG_PAT [TAG_LONG_LEN] = '{
      8'h3C, 8'h3F, 8'h70, 8'h68, 8'h70
   };

   // "<?="
   localparam logic [7:0] TAG_SHORT_PAT [TAG_SHORT_LEN] = '{
      8'h3C, 8'h3F, 8'h3D
   };

   // One input word: a packet byte and its end-of-packet flag.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } pfpm_req_type;

   // One result word, given after the final byte of a packet.
   typedef struct packed {
      logic uri_seen;
      logic tag_seen;
      logic alert;
   } pfpm_rsp_type;

   // Per-cell compare result; a cell outside a pattern's span reports a hit.
   typedef struct packed {
      logic uri;
      logic tag_long;
      logic tag_short;
   } pfpm_hit_type;

endpackage

`default_nettype wire

// File: hdl/packet_fixed_pattern_matcher_top.sv
// Top level of the packet fixed pattern matcher: cell chain, position, flags, result register.
//
// Usage
//   req channel: one packet byte per word (data_byte), last_byte marks the final
//   byte. rsp channel: one word per packet, given after its final byte, carrying
//   uri_seen (script path found), tag_seen ("<?php" or "<?=" found) and alert
//   (both found). Bytes from WINDOW onwards are taken but not scanned, and a
//   match must start before byte WINDOW-40.
//   Throughput: one byte per cycle while no final byte is stalled. A chain of 34
//   history cells shifts every byte along while all cells compare in parallel
//   against the patterns, so each word completes its scan in the cycle it is accepted.
//   Latency: the result word is valid in the cycle after the final byte is
//   accepted, held in an output register.
//   Stall: while a result word waits under rsp_stall, non-final bytes are
//   still taken; only a final byte is stalled until the output register frees.
//   Reset: synchronous, active high; clears position, flags and rsp_valid.
//   The history cells need no clearing, since a match is only counted once
//   enough bytes of the current packet have passed through them.
`default_nettype none

module packet_fixed_pattern_matcher_top #(
   parameter int unsigned WINDOW = pfpm_pkg::WINDOW_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire pfpm_pkg::pfpm_req_type req_word,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output pfpm_pkg::pfpm_rsp_type rsp_word
);

   import pfpm_pkg::*;

   // Position saturates at WINDOW, so it must be able to hold WINDOW itself.
   localparam int unsigned POS_W = $clog2(WINDOW + 1);

   // Last position at which each pattern may end: start < WINDOW - START_MARGIN.
   localparam logic [POS_W-1:0] URI_MAX_END =
      POS_W'(WINDOW - START_MARGIN + URI_LEN - 2);
   localparam logic [POS_W-1:0] TAG_LONG_MAX_END =
      POS_W'(WINDOW - START_MARGIN + TAG_LONG_LEN - 2);
   localparam logic [POS_W-1:0] TAG_SHORT_MAX_END =
      POS_W'(WINDOW - START_MARGIN + TAG_SHORT_LEN - 2);
   localparam logic [POS_W-1:0] URI_MIN_END       = POS_W'(URI_LEN - 1);
   localparam logic [POS_W-1:0] TAG_LONG_MIN_END  = POS_W'(TAG_LONG_LEN - 1);
   localparam logic [POS_W-1:0] TAG_SHORT_MIN_END = POS_W'(TAG_SHORT_LEN - 1);
   localparam logic [POS_W-1:0] WINDOW_POS        = POS_W'(WINDOW);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             uri_found_ff, uri_found_in;
   logic             tag_found_ff, tag_found_in;
   logic             rsp_valid_ff, rsp_valid_in;
   pfpm_rsp_type     rsp_word_ff, rsp_word_in;

   logic             req_take;
   logic             in_window;
   logic             shift_en;
   logic [7:0]       chain [HIST_LEN+1];
   pfpm_hit_type     cell_hit [HIST_LEN];
   logic [HIST_LEN-1:0] uri_hits, tag_long_hits, tag_short_hits;
   logic             uri_now, tag_long_now, tag_short_now;
   logic             uri_next, tag_next;

   // Hold a final byte only while the previous result word is still stalled.
   assign req_stall = rsp_valid_ff & rsp_stall & req_word.last_byte;
   assign req_take  = req_valid & ~req_stall;
   assign in_window = (pos_ff < WINDOW_POS);
   assign shift_en  = req_take & in_window;

   // History chain: cell 0 takes the incoming byte, each cell feeds the next.
   assign chain[0] = req_word.data_byte;

   for (genvar k = 0; k < HIST_LEN; k++) begin : g_cell
      pfpm_cell #(
         .CELL_INDEX (k)
      ) u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .byte_in  (chain[k]),
         .byte_out (chain[k+1]),
         .hit      (cell_hit[k])
      );
      assign uri_hits[k]       = cell_hit[k].uri;
      assign tag_long_hits[k]  = cell_hit[k].tag_long;
      assign tag_short_hits[k] = cell_hit[k].tag_short;
   end

   // A pattern ends at the current byte when every cell in its span agrees,
   // the current byte is its last byte and the position lies in range.
   assign uri_now = in_window & (&uri_hits)
                  & (req_word.data_byte == URI_PAT[URI_LEN-1])
                  & (pos_ff >= URI_MIN_END) & (pos_ff <= URI_MAX_END);
   assign tag_long_now = in_window & (&tag_long_hits)
                  & (req_word.data_byte == TAG_LONG_PAT[TAG_LONG_LEN-1])
                  & (pos_ff >= TAG_LONG_MIN_END) & (pos_ff <= TAG_LONG_MAX_END);
   assign tag_short_now = in_window & (&tag_short_hits)
                  & (req_word.data_byte == TAG_SHORT_PAT[TAG_SHORT_LEN-1])
                  & (pos_ff >= TAG_SHORT_MIN_END) & (pos_ff <= TAG_SHORT_MAX_END);

   assign uri_next = uri_found_ff | uri_now;
   assign tag_next = tag_found_ff | tag_long_now | tag_short_now;

   always_comb begin
      pos_in       = pos_ff;
      uri_found_in = uri_found_ff;
      tag_found_in = tag_found_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (req_take) begin
         if (req_word.last_byte) begin
            // Report and drop all packet state.
            rsp_word_in.uri_seen = uri_next;
            rsp_word_in.tag_seen = tag_next;
            rsp_word_in.alert    = uri_next & tag_next;
            rsp_valid_in         = 1'b1;
            pos_in               = '0;
            uri_found_in         = 1'b0;
            tag_found_in         = 1'b0;
         end else begin
            uri_found_in = uri_next;
            tag_found_in = tag_next;
            // Advance the position until it saturates at the window end.
            if (in_window) begin
               pos_in = pos_ff + POS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         uri_found_ff <= 1'b0;
         tag_found_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         uri_found_ff <= uri_found_in;
         tag_found_ff <= tag_found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // Position never runs past the window end.
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= WINDOW_POS)
      else $error("position beyond window");

   // A final byte clears all packet state.
   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_word.last_byte) |=>
         (pos_ff == '0) && !uri_found_ff && !tag_found_ff)
      else $error("packet state not cleared after final byte");

   // A final byte always produces a result word next cycle.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_word.last_byte) |=> rsp_valid_ff)
      else $error("result word missing after final byte");

   // A stalled result word is never overwritten by a new final byte.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !(req_take && req_word.last_byte))
      else $error("stalled result word overwritten");

   // Alert is exactly both flags.
   a_alert: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_word_ff.alert == (rsp_word_ff.uri_seen && rsp_word_ff.tag_seen)))
      else $error("alert disagrees with flags");

endmodule

`default_nettype wire

// File: hdl/pfpm_cell.sv
// One history cell: holds a past byte, passes it on and compares it to the patterns.
`default_nettype none

module pfpm_cell #(
   parameter int unsigned CELL_INDEX = 0
) (
   input  wire logic               clock,
   input  wire logic               shift_en,
   input  wire logic [7:0]         byte_in,
   output logic [7:0]              byte_out,
   output pfpm_pkg::pfpm_hit_type  hit
);

   import pfpm_pkg::*;

   // Pattern lanes this cell faces; cells past a tag's span point at lane 0 and never use it.
   localparam int unsigned TAG_LONG_IDX  =
      (CELL_INDEX < TAG_LONG_LEN - 1) ? TAG_LONG_LEN - 2 - CELL_INDEX : 0;
   localparam int unsigned TAG_SHORT_IDX =
      (CELL_INDEX < TAG_SHORT_LEN - 1) ? TAG_SHORT_LEN - 2 - CELL_INDEX : 0;

   logic [7:0] byte_ff;
   logic [7:0] byte_in_mux;

   // Cell k holds the byte k+1 places before the current one.
   assign byte_in_mux = shift_en ? byte_in : byte_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in_mux;
   end

   assign byte_out = byte_ff;

   always_comb begin
      hit.uri       = (byte_ff == URI_PAT[URI_LEN - 2 - CELL_INDEX]);
      hit.tag_long  = 1'b1;
      hit.tag_short = 1'b1;
      if (CELL_INDEX < TAG_LONG_LEN - 1) begin
         hit.tag_long = (byte_ff == TAG_LONG_PAT[TAG_LONG_IDX]);
      end
      if (CELL_INDEX < TAG_SHORT_LEN - 1) begin
         hit.tag_short = (byte_ff == TAG_SHORT_PAT[TAG_SHORT_IDX]);
      end
   end

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the packet fixed pattern matcher: byte stimulus, predictor, scoreboard.

module tb_top;

   import pfpm_pkg::*;

   localparam int unsigned WIN        = WINDOW_DEFAULT;
   localparam int unsigned HIST       = HIST_LEN;
   localparam int unsigned ITEM_GOAL  = 1800;
   localparam int unsigned PKT_GOAL   = 20;
   localparam int unsigned IDLE_LIMIT = 5000;

   // Patterns, right-aligned, first byte in the highest lane.
   // Script path "phpunit/src/Util/PHP/eval-stdin.php".
   localparam logic [279:0] PATH_BYTES = {
      8'h70, 8'h68, 8'h70, 8'h75, 8'h6E, 8'h69, 8'h74, 8'h2F,
      8'h73, 8'h72, 8'h63, 8'h2F, 8'h55, 8'h74, 8'h69, 8'h6C,
      8'h2F, 8'h50, 8'h48, 8'h50, 8'h2F, 8'h65, 8'h76, 8'h61,
      8'h6C, 8'h2D, 8'h73, 8'h74, 8'h64, 8'h69, 8'h6E, 8'h2E,
      8'h70, 8'h68, 8'h70
   };
   localparam logic [279:0] OPEN_TAG_BYTES  = "<?php";
   localparam logic [279:0] ECHO_TAG_BYTES  = "<?=";

   // Scoreboard: tracks the packet in flight and holds the reports still owed.
   class pattern_scoreboard;
      logic [7:0]   history [HIST];
      int unsigned  position;
      bit           path_hit;
      bit           tag_hit;
      pfpm_rsp_type expected_reports [$];
      int unsigned  mismatch_count;

      function new();
         mismatch_count = 0;
         clear_packet();
      endfunction

      function void clear_packet();
         foreach (history[k]) history[k] = 8'h00;
         position = 0;
         path_hit = 1'b0;
         tag_hit  = 1'b0;
      endfunction

      // Does an n-byte pattern end on the current byte at index pos, within the window
      // and starting before the margin?
      function bit pattern_ends_at(logic [279:0] pat, int unsigned n, logic [7:0] cur,
                                   int unsigned pos);
         int unsigned j;
         if (pos >= WIN || pos + 1 < n) return 1'b0;
         if (pos + 1 - n >= WIN - START_MARGIN) return 1'b0;
         if (pat[7:0] != cur) return 1'b0;
         for (j = 0; j + 1 < n; j++)
            if (history[n - 2 - j] != pat[8 * (n - 1 - j) +: 8]) return 1'b0;
         return 1'b1;
      endfunction

      function void take_byte(pfpm_req_type w);
         pfpm_rsp_type rep;
         int unsigned  k;
         if (position < WIN) begin
            if (pattern_ends_at(PATH_BYTES, URI_LEN, w.data_byte, position))
               path_hit = 1'b1;
            if (pattern_ends_at(OPEN_TAG_BYTES, TAG_LONG_LEN, w.data_byte, position) ||
                pattern_ends_at(ECHO_TAG_BYTES, TAG_SHORT_LEN, w.data_byte, position))
               tag_hit = 1'b1;
            for (k = HIST - 1; k > 0; k--) history[k] = history[k - 1];
            history[0] = w.data_byte;
            position++;
         end
         if (w.last_byte) begin
            rep.uri_seen = path_hit;
            rep.tag_seen = tag_hit;
            rep.alert    = path_hit & tag_hit;
            expected_reports.push_back(rep);
            clear_packet();
         end
      endfunction

      function void check_report(pfpm_rsp_type got);
         pfpm_rsp_type want;
         if (expected_reports.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("ERROR: unexpected report uri %0b tag %0b alert %0b",
                        got.uri_seen, got.tag_seen, got.alert);
            return;
         end
         want = expected_reports.pop_front();
         if (got.uri_seen !== want.uri_seen || got.tag_seen !== want.tag_seen ||
             got.alert !== want.alert) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("ERROR: report uri %0b/%0b tag %0b/%0b alert %0b/%0b (expected/actual)",
                        want.uri_seen, got.uri_seen, want.tag_seen, got.tag_seen,
                        want.alert, got.alert);
         end
      endfunction

      function int unsigned outstanding();
         return expected_reports.size();
      endfunction
   endclass

   logic         clock;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   pfpm_req_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   pfpm_rsp_type rsp_word;

   pattern_scoreboard sb = new();

   logic [7:0]  packet_bytes [$];
   int unsigned bytes_sent     = 0;
   int unsigned packets_sent   = 0;
   int unsigned idle_cycles    = 0;
   int unsigned stall_left     = 0;
   bit          sender_calm    = 1'b0;
   bit          receiver_calm  = 1'b0;

   packet_fixed_pattern_matcher_top #(.WINDOW(WIN)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Gap length: mostly none or short, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // Half the bytes come from the pattern alphabet, so near misses are common.
   function automatic logic [7:0] pick_byte();
      int unsigned r;
      if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
      r = $urandom_range(0, 37);
      if (r < URI_LEN) return PATH_BYTES[8 * (URI_LEN - 1 - r) +: 8];
      if (r == 35) return 8'h3C;
      if (r == 36) return 8'h3F;
      return 8'h3D;
   endfunction

   // Monitor: sample both handshakes on the rising edge, before any new drive lands.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_valid && !req_stall) sb.take_byte(req_word);
         if (rsp_valid && !rsp_stall) sb.check_report(rsp_word);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // Result side back-pressure: random stall bursts, with calm stretches of no stall at all.
   always @(posedge clock) begin
      int unsigned len;
      if ($urandom_range(0, 149) == 0) receiver_calm <= !receiver_calm;
      if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (!receiver_calm && $urandom_range(0, 99) < 30) begin
         len = pick_gap();
         rsp_stall  <= (len != 0);
         stall_left <= (len != 0) ? len - 1 : 0;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog: end the run if nothing moves for too long.
   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Offer one word; drop valid for a random gap first unless the sender is calm.
   task automatic push_byte(input logic [7:0] b, input bit is_final);
      int unsigned gap;
      gap = sender_calm ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= '{data_byte: b, last_byte: is_final};
      // Hold the word until the block takes it.
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic send_packet();
      for (int i = 0; i < packet_bytes.size(); i++)
         push_byte(packet_bytes[i], i == packet_bytes.size() - 1);
      packets_sent++;
   endtask

   task automatic append_bytes(input logic [279:0] v, input int unsigned n);
      for (int j = 0; j < n; j++) packet_bytes.push_back(v[8 * (n - 1 - j) +: 8]);
   endtask

   // Overwrite a pattern into the packet; a broken one has one byte spoilt.
   // Anything running past the packet end is cut off.
   task automatic place_pattern(input logic [279:0] v, input int unsigned n,
                                input int unsigned at, input bit broken);
      int unsigned spoil_at;
      logic [7:0]  spoil_mask;
      spoil_at   = $urandom_range(0, n - 1);
      spoil_mask = broken ? 8'($urandom_range(1, 255)) : 8'h00;
      for (int j = 0; j < n && at + j < packet_bytes.size(); j++)
         packet_bytes[at + j] = v[8 * (n - 1 - j) +: 8] ^ ((j == spoil_at) ? spoil_mask : 8'h00);
   endtask

   // Build one random packet: mostly short, a few long enough to cross the margin and window.
   task automatic make_random_packet();
      int unsigned len, patterns, kind, n, at;
      bit          long_pkt;
      logic [279:0] pat;
      packet_bytes.delete();
      long_pkt = ($urandom_range(0, 15) == 0);
      len = long_pkt ? $urandom_range(440, 560) : $urandom_range(1, 70);
      for (int i = 0; i < len; i++) packet_bytes.push_back(pick_byte());
      patterns = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
      repeat (patterns) begin
         kind = $urandom_range(0, 2);
         pat  = (kind == 0) ? PATH_BYTES : (kind == 1) ? OPEN_TAG_BYTES : ECHO_TAG_BYTES;
         n    = (kind == 0) ? URI_LEN : (kind == 1) ? TAG_LONG_LEN : TAG_SHORT_LEN;
         if (long_pkt) begin
            case ($urandom_range(0, 2))
               0: begin
                  // straddle the last allowed start position
                  at = $urandom_range(WIN - START_MARGIN - 3, WIN - START_MARGIN + 2);
               end
               1: begin
                  // around and beyond the end of the window
                  at = $urandom_range(WIN - n - 2, len - 1);
               end
               default: begin
                  at = $urandom_range(0, len - 1);
               end
            endcase
         end else begin
            at = $urandom_range(0, len - 1);
         end
         place_pattern(pat, n, at, $urandom_range(0, 4) == 0);
      end
   endtask

   // Hold the sender until every owed report has come back.
   task automatic drain_reports();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: extreme single bytes, each tag alone, a tag split over two packets,
      // and the path followed by a tag whose final byte closes the packet.
      packet_bytes = '{8'h00};
      send_packet();
      packet_bytes = '{8'hFF};
      send_packet();
      packet_bytes.delete();
      append_bytes(ECHO_TAG_BYTES, TAG_SHORT_LEN);
      send_packet();
      packet_bytes.delete();
      append_bytes(OPEN_TAG_BYTES, TAG_LONG_LEN);
      send_packet();
      packet_bytes = '{8'h3C, 8'h3F};
      send_packet();
      packet_bytes = '{8'h3D};
      send_packet();
      packet_bytes.delete();
      append_bytes(PATH_BYTES, URI_LEN);
      append_bytes(ECHO_TAG_BYTES, TAG_SHORT_LEN);
      send_packet();
      drain_reports();

      // Random packets, with calm stretches and the odd full drain.
      while (bytes_sent < ITEM_GOAL || packets_sent < PKT_GOAL) begin
         if ($urandom_range(0, 9) == 0) sender_calm = !sender_calm;
         make_random_packet();
         send_packet();
         if (packets_sent % 15 == 0) drain_reports();
      end
      req_valid <= 1'b0;

      // Wait for the last reports, then let the output register settle.
      do @(posedge clock); while (sb.outstanding() != 0);
      repeat (5) @(posedge clock);

      if (sb.mismatch_count == 0 && sb.outstanding() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
